// File: rtl/msr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the selection-move remap block.
// Used by move_selected_entries_remap; depends on nothing.
package msr_pkg;

    // Fixed field widths
    localparam int IDX_W  = 8;              // entry_index, new_index
    localparam int SIZE_W = 9;              // palette_size, target_index, counts
    localparam int IDX_SPAN = 1 << IDX_W;   // entries addressable by entry_index

    localparam int DEFAULT_ENTRIES = 256;
    localparam logic [SIZE_W-1:0] PALETTE_SIZE_RESET = 9'd256;

    // Request kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

// File: rtl/move_selected_entries_remap.sv
`timescale 1ns / 1ps
// Timing: write requests are taken back to back while idle. A query scans min(n, DEPTH) entries
// one per cycle through the selection memory read port (m = entries scanned, at most 256); an
// out-of-range query skips the scan. No new request is taken until a query's result is
// registered, and an output stall holds the block in its finish state.
// Reset: async active low; then a clearing pass zeroes the DEPTH entries of the selection memory
// while no request is taken; palette_size resets to 256.
// Top level of the selection-move remap block; depends on msr_pkg.
module move_selected_entries_remap #(
    parameter int ENTRIES = msr_pkg::DEFAULT_ENTRIES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [msr_pkg::SIZE_W-1:0]   cfg_palette_size,
    // request channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         kind,
    input  logic [msr_pkg::IDX_W-1:0]    entry_index,
    input  logic                         selected,
    input  logic [msr_pkg::SIZE_W-1:0]   target_index,
    // result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [msr_pkg::IDX_W-1:0]    new_index,
    output logic                         out_of_range
);

    localparam int SW = msr_pkg::SIZE_W;
    localparam int IW = msr_pkg::IDX_W;
    // Only entries reachable through entry_index need storage
    localparam int DEPTH = (ENTRIES > msr_pkg::IDX_SPAN) ? msr_pkg::IDX_SPAN : ENTRIES;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SIZE_MAX = (1 << SW) - 1;
    localparam int SIZE_CAP = (ENTRIES > SIZE_MAX) ? SIZE_MAX : ENTRIES;

    msr_pkg::state_t state_reg, state_next;

    logic [SW-1:0] palette_size_reg, palette_size_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [IW-1:0] e_reg, e_next;
    logic [SW-1:0] t_reg, t_next;
    logic [SW-1:0] m_reg, m_next;
    logic          oor_reg, oor_next;
    logic [SW-1:0] issue_cnt_reg, issue_cnt_next;
    logic [SW-1:0] rd_idx_reg, rd_idx_next;
    logic          rd_vld_reg, rd_vld_next;
    logic          rd_data_reg;
    logic [SW-1:0] total_reg, total_next;
    logic [SW-1:0] before_t_reg, before_t_next;
    logic [SW-1:0] sel_e_reg, sel_e_next;
    logic [SW-1:0] unsel_e_reg, unsel_e_next;
    logic          pick_e_reg, pick_e_next;
    logic          out_valid_reg, out_valid_next;
    logic [IW-1:0] new_index_reg, new_index_next;
    logic          out_of_range_reg, out_of_range_next;

    logic          mem [DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic [AW-1:0] mem_raddr;

    logic          in_fire;
    logic          write_fire;
    logic          query_fire;
    logic [SW-1:0] n_eff;
    logic          entry_oor;
    logic          write_in_range;
    logic          scan_done;
    logic          out_free;
    logic [SW-1:0] base;
    logic [SW-1:0] dest;

    // Effective palette size and request decode
    always_comb
    begin
        n_eff = (palette_size_reg > SW'(SIZE_CAP)) ? SW'(SIZE_CAP) : palette_size_reg;
        entry_oor = ({1'b0, entry_index} >= n_eff);
        write_in_range = (32'(entry_index) < 32'(ENTRIES));
        in_fire = in_valid && in_ready;
        write_fire = in_fire && (kind == msr_pkg::KIND_WRITE);
        query_fire = in_fire && (kind == msr_pkg::KIND_QUERY);
        scan_done = (issue_cnt_reg == m_reg) && !rd_vld_reg;
        out_free = !out_valid_reg || out_ready;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msr_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(DEPTH - 1))
                    state_next = msr_pkg::ST_IDLE;
            end
            msr_pkg::ST_IDLE:
            begin
                if (query_fire)
                    state_next = entry_oor ? msr_pkg::ST_FINISH : msr_pkg::ST_SCAN;
            end
            msr_pkg::ST_SCAN:
            begin
                if (scan_done)
                    state_next = msr_pkg::ST_FINISH;
            end
            msr_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = msr_pkg::ST_IDLE;
            end
            default:
                state_next = msr_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_ready  = (state_reg == msr_pkg::ST_IDLE);
        cfg_ready = 1'b1;
        mem_raddr = issue_cnt_reg[AW-1:0];
        case (state_reg)
            msr_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = 1'b0;
            end
            msr_pkg::ST_IDLE:
            begin
                mem_we    = write_fire && write_in_range;
                mem_waddr = entry_index[AW-1:0];
                mem_wdata = selected;
            end
            default:
            begin
                mem_we    = 1'b0;
                mem_waddr = entry_index[AW-1:0];
                mem_wdata = selected;
            end
        endcase
    end

    // Destination from the finished counts
    always_comb
    begin
        base = t_reg - before_t_reg;
        if (pick_e_reg)
            dest = base + sel_e_reg;
        else if (unsel_e_reg < base)
            dest = unsel_e_reg;
        else
            dest = unsel_e_reg + total_reg;
    end

    // Datapath
    always_comb
    begin
        palette_size_next = palette_size_reg;
        clr_cnt_next      = clr_cnt_reg;
        e_next            = e_reg;
        t_next            = t_reg;
        m_next            = m_reg;
        oor_next          = oor_reg;
        issue_cnt_next    = issue_cnt_reg;
        rd_idx_next       = rd_idx_reg;
        rd_vld_next       = 1'b0;
        total_next        = total_reg;
        before_t_next     = before_t_reg;
        sel_e_next        = sel_e_reg;
        unsel_e_next      = unsel_e_reg;
        pick_e_next       = pick_e_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        new_index_next    = new_index_reg;
        out_of_range_next = out_of_range_reg;

        if (cfg_valid && cfg_ready)
            palette_size_next = cfg_palette_size;

        if (state_reg == msr_pkg::ST_CLEAR)
            clr_cnt_next = clr_cnt_reg + AW'(1);

        if (query_fire)
        begin
            e_next         = entry_index;
            t_next         = (target_index > n_eff) ? n_eff : target_index;
            m_next         = (n_eff > SW'(DEPTH)) ? SW'(DEPTH) : n_eff;
            oor_next       = entry_oor;
            issue_cnt_next = '0;
            total_next     = '0;
            before_t_next  = '0;
            sel_e_next     = '0;
            unsel_e_next   = '0;
            pick_e_next    = 1'b0;
        end

        if (state_reg == msr_pkg::ST_SCAN)
        begin
            // Issue one read a cycle; count the entry read last cycle
            if (issue_cnt_reg != m_reg)
            begin
                issue_cnt_next = issue_cnt_reg + SW'(1);
                rd_idx_next    = issue_cnt_reg;
                rd_vld_next    = 1'b1;
            end
            if (rd_vld_reg)
            begin
                if (rd_data_reg)
                begin
                    total_next = total_reg + SW'(1);
                    if (rd_idx_reg < t_reg)
                        before_t_next = before_t_reg + SW'(1);
                    if (rd_idx_reg < {1'b0, e_reg})
                        sel_e_next = sel_e_reg + SW'(1);
                end
                else if (rd_idx_reg < {1'b0, e_reg})
                begin
                    unsel_e_next = unsel_e_reg + SW'(1);
                end
                if (rd_idx_reg == {1'b0, e_reg})
                    pick_e_next = rd_data_reg;
            end
        end

        if ((state_reg == msr_pkg::ST_FINISH) && out_free)
        begin
            out_valid_next    = 1'b1;
            out_of_range_next = oor_reg;
            new_index_next    = oor_reg ? '0 : dest[IW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= msr_pkg::ST_CLEAR;
            palette_size_reg <= msr_pkg::PALETTE_SIZE_RESET;
            clr_cnt_reg      <= '0;
            rd_vld_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            palette_size_reg <= palette_size_next;
            clr_cnt_reg      <= clr_cnt_next;
            rd_vld_reg       <= rd_vld_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg            <= e_next;
        t_reg            <= t_next;
        m_reg            <= m_next;
        oor_reg          <= oor_next;
        issue_cnt_reg    <= issue_cnt_next;
        rd_idx_reg       <= rd_idx_next;
        total_reg        <= total_next;
        before_t_reg     <= before_t_next;
        sel_e_reg        <= sel_e_next;
        unsel_e_reg      <= unsel_e_next;
        pick_e_reg       <= pick_e_next;
        new_index_reg    <= new_index_next;
        out_of_range_reg <= out_of_range_next;
    end

    // Selection memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    assign out_valid    = out_valid_reg;
    assign new_index    = new_index_reg;
    assign out_of_range = out_of_range_reg;

`ifndef SYNTHESIS
    a_counts_below_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msr_pkg::ST_SCAN) |-> ((sel_e_reg + unsel_e_reg) <= {1'b0, e_reg}))
        else $error("entries counted below the queried entry exceed its index");

    a_before_t_in_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msr_pkg::ST_SCAN || state_reg == msr_pkg::ST_FINISH)
        |-> (before_t_reg <= total_reg))
        else $error("selected count before insertion point exceeds total");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msr_pkg::ST_SCAN) |-> (issue_cnt_reg <= m_reg))
        else $error("scan issued past the palette size");

    a_oor_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_of_range_reg) |-> (new_index_reg == '0))
        else $error("out-of-range result carries a nonzero index");
`endif

endmodule
